>>> hdl/evi_savi_pixel_index_defines.svh
// ---------------------------------------------------------------------------
// evi_savi_pixel_index assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef EVI_SAVI_PIXEL_INDEX_DEFINES_SVH
`define EVI_SAVI_PIXEL_INDEX_DEFINES_SVH

// same-cycle implication
`define EVISAVI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("evisavi: assertion failed");

// next-cycle implication
`define EVISAVI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("evisavi: assertion failed");

`endif

>>> hdl/evisavi_pkg.sv
// ---------------------------------------------------------------------------
// evisavi_pkg
// widths, register indexes, reset values and shared types of the index block
// ---------------------------------------------------------------------------
package evisavi_pkg;

	// reflectance format
	localparam int REFL_W              = 16;
	localparam int REFL_FRAC_BITS_DEF  = 14;

	// result format
	localparam int IDX_W    = 27;
	localparam int CLH_W    = 26;
	localparam int FORM_W   = 2;
	localparam int QFRAC_W  = 16;

	// internal datapath widths
	localparam int DIFF_W   = REFL_W + 1;
	localparam int NUM_W    = REFL_W + 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;

	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNDEF_VAL  = 2'd2;

	localparam logic signed [IDX_W-1:0] CLAMP_LOW_RST  = -27'sd65536000;
	localparam logic        [CLH_W-1:0] CLAMP_HIGH_RST = 26'd65536000;
	localparam logic signed [IDX_W-1:0] UNDEF_VAL_RST  = -27'sd131072;

	// formula codes
	localparam logic [FORM_W-1:0] FORM_UNDEF = 2'd0;
	localparam logic [FORM_W-1:0] FORM_EVI   = 2'd1;
	localparam logic [FORM_W-1:0] FORM_SAVI  = 2'd2;

	// side information that travels with a division
	typedef struct packed {
		logic              undef;
		logic              neg;
		logic [FORM_W-1:0] formula;
		logic              last;
	} div_tag_t;

endpackage

>>> hdl/evisavi_if.sv
// ---------------------------------------------------------------------------
// evisavi channel interfaces
// pixel request, index result and register write channels
// ---------------------------------------------------------------------------

// pixel request channel
interface evisavi_pix_if;
	import evisavi_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [REFL_W-1:0] blue_refl;
	logic signed [REFL_W-1:0] red_refl;
	logic signed [REFL_W-1:0] nir_refl;
	logic                     last_pixel;

	modport source (output valid, blue_refl, red_refl, nir_refl, last_pixel, input ready);
	modport sink (input valid, blue_refl, red_refl, nir_refl, last_pixel, output ready);
endinterface

// index result channel
interface evisavi_res_if;
	import evisavi_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [IDX_W-1:0] index_value;
	logic [FORM_W-1:0]       formula_used;
	logic                    last_out;

	modport source (output valid, index_value, formula_used, last_out, input ready);
	modport sink (input valid, index_value, formula_used, last_out, output ready);
endinterface

// register write channel
interface evisavi_cfg_if;
	import evisavi_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> hdl/evisavi_div.sv
// ---------------------------------------------------------------------------
// evisavi_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`include "evi_savi_pixel_index_defines.svh"

module evisavi_div #(
	parameter int DVD_W = 36,
	parameter int DVS_W = 22
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DVD_W-1:0]       in_dvd,
	input  logic [DVS_W-1:0]       in_dvs,
	input  evisavi_pkg::div_tag_t  in_tag,
	output logic                   out_valid,
	output logic [DVD_W-1:0]       out_quo,
	output evisavi_pkg::div_tag_t  out_tag
);
	import evisavi_pkg::*;

	localparam int N = DVD_W;

	// stage registers: remainder, dividend shifting into quotient, divisor
	logic [N:1]       v_s;
	logic [DVS_W-1:0] rem_s [1:N];
	logic [DVD_W-1:0] dvd_s [1:N];
	logic [DVS_W-1:0] dvs_s [1:N];
	div_tag_t         tag_s [1:N];

	logic [DVS_W-1:0] rem_nx [1:N];
	logic [DVD_W-1:0] dvd_nx [1:N];
	logic [DVS_W-1:0] dvs_nx [1:N];
	div_tag_t         tag_nx [1:N];

	// one trial subtraction per stage
	always_comb begin
		logic [DVS_W-1:0] rem_p;
		logic [DVD_W-1:0] dvd_p;
		logic [DVS_W-1:0] dvs_p;
		div_tag_t         tag_p;
		logic [DVS_W:0]   shifted;
		logic [DVS_W:0]   trial;
		logic             qbit;
		for (int k = 1; k <= N; k++) begin
			if (k == 1) begin
				rem_p = '0;
				dvd_p = in_dvd;
				dvs_p = in_dvs;
				tag_p = in_tag;
			end else begin
				rem_p = rem_s[k-1];
				dvd_p = dvd_s[k-1];
				dvs_p = dvs_s[k-1];
				tag_p = tag_s[k-1];
			end
			shifted   = {rem_p, dvd_p[DVD_W-1]};
			trial     = shifted - {1'b0, dvs_p};
			qbit      = !trial[DVS_W];
			rem_nx[k] = qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			dvd_nx[k] = {dvd_p[DVD_W-2:0], qbit};
			dvs_nx[k] = dvs_p;
			tag_nx[k] = tag_p;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-1:1], in_valid};
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= N; k++) begin
				rem_s[k] <= rem_nx[k];
				dvd_s[k] <= dvd_nx[k];
				dvs_s[k] <= dvs_nx[k];
				tag_s[k] <= tag_nx[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_quo   = dvd_s[N];
	assign out_tag   = tag_s[N];

	// remainder stays below a nonzero divisor
	`EVISAVI_ASSERT_IMP(a_rem_below_dvs, v_s[N] && (dvs_s[N] != '0), rem_s[N] < dvs_s[N])
	// a stall freezes the pipe
	`EVISAVI_ASSERT_NXT(a_stall_holds, !en, $stable(v_s) && $stable(dvd_s[N]))
	// valid bits move one stage per enabled cycle
	`EVISAVI_ASSERT_NXT(a_valid_shift, en, v_s[N] == $past(v_s[N-1]))

endmodule

>>> hdl/evi_savi_pixel_index.sv
// ---------------------------------------------------------------------------
// evi_savi_pixel_index
// per-pixel EVI index with SAVI fallback, Q1.14 in, clamped Q10.16 out
// ---------------------------------------------------------------------------
// One pixel request is taken per clock while no result is stalled, and each
// gives one result, in order. Three stages form the numerator and
// denominator, a 36-stage restoring divider (one quotient bit per stage)
// follows, and three stages restore the sign, clamp and select the
// undefined value. A stalled result holds the whole pipe; a one-entry skid
// register keeps the input ready registered, so one more request is taken
// while a result waits. Register writes take effect immediately and are
// meant for idle periods.
`include "evi_savi_pixel_index_defines.svh"

module evi_savi_pixel_index #(
	parameter int REFL_FRAC_BITS = evisavi_pkg::REFL_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	evisavi_pix_if.sink  pix,
	evisavi_res_if.source res,
	evisavi_cfg_if.sink  cfg
);
	import evisavi_pkg::*;

	localparam int DEN_MAG = (REFL_FRAC_BITS + 2 > 20) ? REFL_FRAC_BITS + 2 : 20;
	localparam int DEN_W   = DEN_MAG + 2;
	localparam int DVD_W   = NUM_W + QFRAC_W;
	localparam int Q_W     = DVD_W + 1;

	localparam logic signed [DEN_W-1:0] BASE_EVI  = DEN_W'(2) << REFL_FRAC_BITS;
	localparam logic signed [DEN_W-1:0] BASE_SAVI = DEN_W'(1) << REFL_FRAC_BITS;

	// configuration registers
	logic signed [IDX_W-1:0] clamp_low_q;
	logic        [CLH_W-1:0] clamp_high_q;
	logic signed [IDX_W-1:0] undefined_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_low_q  <= CLAMP_LOW_RST;
			clamp_high_q <= CLAMP_HIGH_RST;
			undefined_q  <= UNDEF_VAL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_CLAMP_LOW:  clamp_low_q  <= cfg.wdata[IDX_W-1:0];
				REG_CLAMP_HIGH: clamp_high_q <= cfg.wdata[CLH_W-1:0];
				REG_UNDEF_VAL:  undefined_q  <= cfg.wdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// pipe enable and input skid
	logic run;
	logic in_fire;
	logic skid_full_q;
	logic signed [REFL_W-1:0] sk_blu_q, sk_red_q, sk_nir_q;
	logic                     sk_last_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign run       = !v_s6 || res.ready;
	assign pix.ready = !skid_full_q;
	assign in_fire   = pix.valid && !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else begin
			skid_full_q <= run ? 1'b0 : (skid_full_q || in_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			sk_blu_q  <= pix.blue_refl;
			sk_red_q  <= pix.red_refl;
			sk_nir_q  <= pix.nir_refl;
			sk_last_q <= pix.last_pixel;
		end
	end

	// stage 1: classify, difference and denominator terms
	logic signed [REFL_W-1:0] src_blu, src_red, src_nir;
	logic                     src_last, src_valid;
	logic                     blu_pos, red_pos, nir_pos, use_evi;
	logic signed [DEN_W-1:0]  blu_x, red_x, nir_x;
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [DEN_W-1:0]  sum_c, sub_c;

	always_comb begin
		src_blu   = skid_full_q ? sk_blu_q  : pix.blue_refl;
		src_red   = skid_full_q ? sk_red_q  : pix.red_refl;
		src_nir   = skid_full_q ? sk_nir_q  : pix.nir_refl;
		src_last  = skid_full_q ? sk_last_q : pix.last_pixel;
		src_valid = skid_full_q || pix.valid;
		blu_pos   = !src_blu[REFL_W-1] && (src_blu != '0);
		red_pos   = !src_red[REFL_W-1] && (src_red != '0);
		nir_pos   = !src_nir[REFL_W-1] && (src_nir != '0);
		use_evi   = blu_pos && ((src_blu <= src_red) || (src_red <= src_nir));
		blu_x     = DEN_W'(src_blu);
		red_x     = DEN_W'(src_red);
		nir_x     = DEN_W'(src_nir);
		diff_c    = DIFF_W'(src_nir) - DIFF_W'(src_red);
		sum_c     = (nir_x <<< 1) + (use_evi ? (red_x <<< 3) + (red_x <<< 2) : (red_x <<< 1));
		sub_c     = use_evi ? (blu_x <<< 4) - blu_x : '0;
	end

	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [DEN_W-1:0]  sum_s1, sub_s1;
	logic                     evi_s1, ok_s1, last_s1;

	always_ff @(posedge clk) begin
		if (run) begin
			diff_s1 <= diff_c;
			sum_s1  <= sum_c;
			sub_s1  <= sub_c;
			evi_s1  <= use_evi;
			ok_s1   <= red_pos && nir_pos;
			last_s1 <= src_last;
		end
	end

	// stage 2: numerator and denominator
	logic signed [NUM_W-1:0] diff_x, num_c;
	logic signed [DEN_W-1:0] den_c;

	always_comb begin
		diff_x = NUM_W'(diff_s1);
		num_c  = evi_s1 ? (diff_x <<< 2) + diff_x : (diff_x <<< 1) + diff_x;
		den_c  = (evi_s1 ? BASE_EVI : BASE_SAVI) + sum_s1 - sub_s1;
	end

	logic signed [NUM_W-1:0] num_s2;
	logic signed [DEN_W-1:0] den_s2;
	logic                    evi_s2, ok_s2, last_s2;

	always_ff @(posedge clk) begin
		if (run) begin
			num_s2  <= num_c;
			den_s2  <= den_c;
			evi_s2  <= evi_s1;
			ok_s2   <= ok_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: magnitudes, sign and undefined flag
	logic [NUM_W-1:0] num_mag_c;
	logic [DEN_W-1:0] den_mag_c;
	div_tag_t         tag_c;

	always_comb begin
		num_mag_c     = num_s2[NUM_W-1] ? NUM_W'(-num_s2) : NUM_W'(num_s2);
		den_mag_c     = den_s2[DEN_W-1] ? DEN_W'(-den_s2) : DEN_W'(den_s2);
		tag_c.undef   = !ok_s2 || (den_s2 == '0);
		tag_c.neg     = num_s2[NUM_W-1] ^ den_s2[DEN_W-1];
		tag_c.formula = tag_c.undef ? FORM_UNDEF : (evi_s2 ? FORM_EVI : FORM_SAVI);
		tag_c.last    = last_s2;
	end

	logic [NUM_W-1:0] num_mag_s3;
	logic [DEN_W-1:0] den_mag_s3;
	div_tag_t         tag_s3;

	always_ff @(posedge clk) begin
		if (run) begin
			num_mag_s3 <= num_mag_c;
			den_mag_s3 <= den_mag_c;
			tag_s3     <= tag_c;
		end
	end

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (run) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// divider
	logic             div_valid;
	logic [DVD_W-1:0] div_quo;
	div_tag_t         div_tag;

	evisavi_div #(
		.DVD_W (DVD_W),
		.DVS_W (DEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.in_valid  (v_s3),
		.in_dvd    ({num_mag_s3, {QFRAC_W{1'b0}}}),
		.in_dvs    (den_mag_s3),
		.in_tag    (tag_s3),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_tag   (div_tag)
	);

	// stage 4: signed quotient
	logic signed [Q_W-1:0] quo_x;
	logic signed [Q_W-1:0] q_s4;
	div_tag_t              tag_s4;

	assign quo_x = $signed({1'b0, div_quo});

	always_ff @(posedge clk) begin
		if (run) begin
			q_s4   <= div_tag.neg ? -quo_x : quo_x;
			tag_s4 <= div_tag;
		end
	end

	// stage 5: raise to the low limit
	logic signed [Q_W-1:0] cl_x;
	logic signed [Q_W-1:0] lo_s5;
	div_tag_t              tag_s5;

	assign cl_x = Q_W'(clamp_low_q);

	always_ff @(posedge clk) begin
		if (run) begin
			lo_s5  <= (q_s4 < cl_x) ? cl_x : q_s4;
			tag_s5 <= tag_s4;
		end
	end

	// stage 6: lower to the high limit, undefined select, output register
	logic signed [Q_W-1:0]   ch_x;
	logic signed [Q_W-1:0]   hi_c;
	logic signed [IDX_W-1:0] idx_s6;
	logic [FORM_W-1:0]       form_s6;
	logic                    last_s6;

	assign ch_x = $signed({{(Q_W-CLH_W){1'b0}}, clamp_high_q});
	assign hi_c = (lo_s5 > ch_x) ? ch_x : lo_s5;

	always_ff @(posedge clk) begin
		if (run) begin
			idx_s6  <= tag_s5.undef ? undefined_q : hi_c[IDX_W-1:0];
			form_s6 <= tag_s5.formula;
			last_s6 <= tag_s5.last;
		end
	end

	// back valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (run) begin
			v_s4 <= div_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign res.valid        = v_s6;
	assign res.index_value  = idx_s6;
	assign res.formula_used = form_s6;
	assign res.last_out     = last_s6;

	// result views for the checks below
	logic                    res_undef;
	logic                    res_def;
	logic                    lim_ordered;
	logic                    in_limits;
	logic signed [IDX_W-1:0] high_lim;

	assign high_lim    = $signed({1'b0, clamp_high_q});
	assign res_undef   = res.valid && (res.formula_used == FORM_UNDEF);
	assign res_def     = res.valid && (res.formula_used != FORM_UNDEF);
	assign lim_ordered = clamp_low_q <= high_lim;
	assign in_limits   = (res.index_value >= clamp_low_q) && (res.index_value <= high_lim);

	// undefined results carry the programmed value
	`EVISAVI_ASSERT_IMP(a_undef_value, res_undef, res.index_value == undefined_q)
	// defined results stay inside ordered limits
	`EVISAVI_ASSERT_IMP(a_clamp_range, res_def && lim_ordered, in_limits)
	// skid fills only behind a stall
	`EVISAVI_ASSERT_IMP(a_skid_after_stall, skid_full_q, !$past(run))

endmodule

>>> tb/sv/evi_savi_pixel_index_checker.sv
// ---------------------------------------------------------------------------
// evi_savi_pixel_index checker
// watches the pixel, result and register channels, predicts the index of
// every accepted pixel request and compares each result in arrival order
// ---------------------------------------------------------------------------
module evi_savi_pixel_index_checker #(
	parameter int FRAC_BITS = evisavi_pkg::REFL_FRAC_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	evisavi_pix_if pix,
	evisavi_res_if res,
	evisavi_cfg_if cfg,
	output int     fail_count,
	output int     pending,
	output int     evi_count,
	output int     savi_count,
	output int     undef_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import evisavi_pkg::*;

	typedef struct packed {
		logic signed [IDX_W-1:0] value;
		logic [FORM_W-1:0]       formula;
		logic                    last;
	} index_result_t;

	index_result_t expected_idx_q[$];

	// register copies, held wide so clamping compares full values
	longint low_limit;
	longint high_limit;
	longint undef_value;

	int errors;
	int n_evi;
	int n_savi;
	int n_undef;

	// index of one pixel under the current register settings
	function automatic index_result_t compute_index(logic signed [REFL_W-1:0] blu_in,
			logic signed [REFL_W-1:0] red_in, logic signed [REFL_W-1:0] nir_in,
			logic last_in);
		longint b;
		longint r;
		longint n;
		longint num;
		longint den;
		longint q;
		logic [FORM_W-1:0] f;
		index_result_t o;
		b = blu_in;
		r = red_in;
		n = nir_in;
		o.value = undef_value[IDX_W-1:0];
		o.formula = FORM_UNDEF;
		o.last = last_in;
		if (r > 0 && n > 0) begin
			// evi when blue is usable, soil-adjusted fallback otherwise
			if (b > 0 && (b <= r || r <= n)) begin
				num = 5 * (n - r);
				den = (longint'(2) << FRAC_BITS) + 2 * n + 12 * r - 15 * b;
				f = FORM_EVI;
			end else begin
				num = 3 * (n - r);
				den = (longint'(1) << FRAC_BITS) + 2 * n + 2 * r;
				f = FORM_SAVI;
			end
			// zero denominator keeps the undefined value, unclamped
			if (den != 0) begin
				q = (num * 65536) / den;
				if (q < low_limit)
					q = low_limit;
				if (q > high_limit)
					q = high_limit;
				o.value = q[IDX_W-1:0];
				o.formula = f;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		index_result_t want;
		index_result_t got;
		if (!arst_n) begin
			expected_idx_q.delete();
			low_limit = CLAMP_LOW_RST;
			high_limit = CLAMP_HIGH_RST;
			undef_value = UNDEF_VAL_RST;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_CLAMP_LOW:  low_limit = $signed(cfg.wdata);
					REG_CLAMP_HIGH: high_limit = cfg.wdata[CLH_W-1:0];
					REG_UNDEF_VAL:  undef_value = $signed(cfg.wdata);
					default: ;
				endcase
			end

			// accepted pixel requests
			if (pix.valid && pix.ready)
				expected_idx_q.push_back(compute_index(pix.blue_refl, pix.red_refl,
					pix.nir_refl, pix.last_pixel));

			// accepted results against the oldest prediction
			if (res.valid && res.ready) begin
				got.value = res.index_value;
				got.formula = res.formula_used;
				got.last = res.last_out;
				if (expected_idx_q.size() == 0) begin
					errors++;
					$error("result with no pixel pending: index_value %0d formula_used %0d",
						got.value, got.formula);
				end else begin
					want = expected_idx_q.pop_front();
					if (got.value !== want.value) begin
						errors++;
						$error("index_value expected %0d actual %0d", want.value, got.value);
					end
					if (got.formula !== want.formula) begin
						errors++;
						$error("formula_used expected %0d actual %0d", want.formula,
							got.formula);
					end
					if (got.last !== want.last) begin
						errors++;
						$error("last_out expected %0d actual %0d", want.last, got.last);
					end
					case (want.formula)
						FORM_EVI:  n_evi++;
						FORM_SAVI: n_savi++;
						default:   n_undef++;
					endcase
				end
			end
		end
		fail_count <= errors;
		pending <= expected_idx_q.size();
		evi_count <= n_evi;
		savi_count <= n_savi;
		undef_count <= n_undef;
	end

endmodule

>>> tb/sv/evi_savi_pixel_index_tb.sv
// ---------------------------------------------------------------------------
// evi_savi_pixel_index testbench
// directed corner pixels, then random pixel streams under several register
// settings and handshake pacing modes; a checker beside the block predicts
// and compares every result
// ---------------------------------------------------------------------------
module evi_savi_pixel_index_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import evisavi_pkg::*;

	localparam int FRAC_BITS    = REFL_FRAC_BITS_DEF;
	localparam int N_PHASES     = 8;
	localparam int PHASE_PIXELS = 225;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	// index past the register list, ignored by the block
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int cycle_count = 0;

	int fail_count;
	int pending;
	int evi_count;
	int savi_count;
	int undef_count;

	evisavi_pix_if pix ();
	evisavi_res_if res ();
	evisavi_cfg_if cfg ();

	evi_savi_pixel_index #(
		.REFL_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.res(res),
		.cfg(cfg)
	);

	evi_savi_pixel_index_checker #(
		.FRAC_BITS(FRAC_BITS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.res(res),
		.cfg(cfg),
		.fail_count(fail_count),
		.pending(pending),
		.evi_count(evi_count),
		.savi_count(savi_count),
		.undef_count(undef_count)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// result side stalls
	always @(posedge clk) begin
		res.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("evi_savi_pixel_index: mismatch");
			$finish;
		end
	end

	// one pixel request, with random gaps ahead of it
	task automatic send_pixel(logic signed [REFL_W-1:0] blu, logic signed [REFL_W-1:0] red,
			logic signed [REFL_W-1:0] nir, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.blue_refl <= blu;
		pix.red_refl <= red;
		pix.nir_refl <= nir;
		pix.last_pixel <= last;
		do @(posedge clk); while (!pix.ready);
	endtask

	// one register write request, valid left high for a following write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int phase;
		int i;
		int kind;
		int tmp;
		logic signed [REFL_W-1:0] blu;
		logic signed [REFL_W-1:0] red;
		logic signed [REFL_W-1:0] nir;

		pix.valid <= 1'b0;
		pix.blue_refl <= '0;
		pix.red_refl <= '0;
		pix.nir_refl <= '0;
		pix.last_pixel <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.reg_index <= REG_CLAMP_LOW;
		cfg.wdata <= '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners under reset register values
		send_pixel(16'sd0, 16'sd0, 16'sd0, 1'b0);               // red and nir zero
		send_pixel(16'sd1000, 16'sd0, 16'sd8000, 1'b1);         // red zero
		send_pixel(16'sd1000, 16'sd2000, 16'sd0, 1'b0);         // nir zero
		send_pixel(16'sd100, 16'sh8000, 16'sd32767, 1'b1);      // red most negative
		send_pixel(16'sd100, 16'sd32767, 16'sh8000, 1'b0);      // nir most negative
		send_pixel(16'sd1000, 16'sd2000, 16'sd8000, 1'b0);      // plain evi
		send_pixel(-16'sd100, 16'sd2000, 16'sd8000, 1'b1);      // negative blue, savi
		send_pixel(16'sd0, 16'sd2000, 16'sd8000, 1'b0);         // zero blue, savi
		send_pixel(16'sd5000, 16'sd2000, 16'sd1000, 1'b0);      // blue above red, red above nir
		send_pixel(16'sd1500, 16'sd2000, 16'sd1000, 1'b1);      // evi through blue <= red
		send_pixel(16'sd2192, 16'sd8, 16'sd8, 1'b0);            // evi denominator zero
		send_pixel(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);   // all max, zero numerator
		send_pixel(16'sd32767, 16'sd32767, 16'sd32766, 1'b0);   // denominator minus one
		send_pixel(16'sd6553, 16'sd1, 16'sd32758, 1'b0);        // huge positive, clamps high
		send_pixel(16'sd28399, 16'sd32767, 16'sd7, 1'b1);       // huge negative, clamps low
		send_pixel(16'sd32767, 16'sd1, 16'sd32767, 1'b1);       // negative evi denominator
		send_pixel(16'sh8000, 16'sd32767, 16'sd1, 1'b0);        // savi most negative
		send_pixel(16'sh8000, 16'sd1, 16'sd32767, 1'b1);        // savi most positive
		send_pixel(16'sd1, 16'sd1, 16'sd1, 1'b0);               // smallest positive
		send_pixel(16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1);      // all minus one
		pix.valid <= 1'b0;
		wait_drained();

		// random pixel streams, one register setting and pacing mode per phase
		for (phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_CLAMP_LOW, CLAMP_LOW_RST);
					write_reg(REG_CLAMP_HIGH, CLAMP_HIGH_RST);
					write_reg(REG_UNDEF_VAL, UNDEF_VAL_RST);
				end
				1: begin
					// both limits at zero, undefined at the high limit's reset value
					write_reg(REG_CLAMP_LOW, '0);
					write_reg(REG_CLAMP_HIGH, '0);
					write_reg(REG_UNDEF_VAL, CFG_DATA_W'(65536000));
				end
				2: begin
					write_reg(REG_CLAMP_LOW, CFG_DATA_W'(-65536));
					write_reg(REG_CLAMP_HIGH, CFG_DATA_W'(65536));
					write_reg(REG_UNDEF_VAL, '0);
				end
				3: begin
					// low limit above high limit
					write_reg(REG_CLAMP_LOW, CFG_DATA_W'(100000));
					write_reg(REG_CLAMP_HIGH, CFG_DATA_W'(50000));
					write_reg(REG_UNDEF_VAL, CFG_DATA_W'(-65536000));
				end
				4: begin
					write_reg(REG_CLAMP_LOW, CFG_DATA_W'($urandom));
					write_reg(REG_CLAMP_HIGH, CFG_DATA_W'($urandom));
					write_reg(REG_UNDEF_VAL, CFG_DATA_W'($urandom));
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
				end
				5: begin
					// full register widths
					write_reg(REG_CLAMP_LOW, 27'h4000000);
					write_reg(REG_CLAMP_HIGH, 27'h3FFFFFF);
					write_reg(REG_UNDEF_VAL, 27'h3FFFFFF);
				end
				6: begin
					write_reg(REG_CLAMP_LOW, CFG_DATA_W'(-65536000));
					write_reg(REG_CLAMP_HIGH, CFG_DATA_W'(65536000));
					write_reg(REG_UNDEF_VAL, CFG_DATA_W'(-1));
					write_reg(REG_UNUSED, '0);
				end
				default: begin
					write_reg(REG_CLAMP_LOW, CFG_DATA_W'(-int'($urandom_range(65536000))));
					write_reg(REG_CLAMP_HIGH, CFG_DATA_W'($urandom_range(65536000)));
					write_reg(REG_UNDEF_VAL,
						CFG_DATA_W'(int'($urandom_range(131072000)) - 65536000));
				end
			endcase
			cfg.valid <= 1'b0;

			case (phase % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 57;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 57;
				end
				default: begin
					tx_idle_pct = 10;
					rx_stall_pct = 10;
				end
			endcase

			for (i = 0; i < PHASE_PIXELS; i++) begin
				kind = $urandom_range(99);
				blu = REFL_W'($urandom);
				red = REFL_W'($urandom);
				nir = REFL_W'($urandom);
				if (kind < 68) begin
					// valid pixel, sometimes with small bands for large quotients
					red = REFL_W'($urandom_range(32767, 1));
					nir = REFL_W'($urandom_range(32767, 1));
					if (kind < 17) begin
						red = REFL_W'($urandom_range(64, 1));
						nir = REFL_W'($urandom_range(64, 1));
						blu = REFL_W'($urandom_range(64)) - 16'sd8;
					end
				end else if (kind < 82) begin
					// evi denominator near zero
					red = REFL_W'($urandom_range(2000, 1));
					nir = REFL_W'($urandom_range(32767, 1));
					tmp = (32768 + 2 * int'(nir) + 12 * int'(red)) / 15
						+ int'($urandom_range(2)) - 1;
					blu = REFL_W'(tmp);
				end
				send_pixel(blu, red, nir, 1'($urandom_range(1)));
			end
			pix.valid <= 1'b0;
			wait_drained();
		end

		rx_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels checked: %0d evi, %0d savi, %0d undefined",
			evi_count + savi_count + undef_count, evi_count, savi_count, undef_count);
		$display("reset limits plus %0d register settings, four pacing modes", N_PHASES);
		if (fail_count == 0)
			$display("evi_savi_pixel_index: match");
		else
			$display("evi_savi_pixel_index: mismatch");
		$finish;
	end

endmodule
